### src/date_time_string_parse_core_assert.svh
// Assertion macros used by the date/time string decoder checker.
`ifndef DATE_TIME_STRING_PARSE_CORE_ASSERT_SVH
`define DATE_TIME_STRING_PARSE_CORE_ASSERT_SVH

// Concurrent assertion on clk, disabled while rst_n is low.
`define DTSP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("date_time_string_parse_core: assertion failed");

// Condition in one cycle implies the expression in the next.
`define DTSP_ASSERT_NEXT(label, cond, expr) \
  `DTSP_ASSERT(label, (cond) |=> (expr))

`endif

### src/dtsp_pkg.sv
// Types, constants and pair decode function for the date/time string decoder.
package dtsp_pkg;

  localparam int StoreDepth = 15;
  localparam int CountSat   = 16;
  localparam int CountW     = 5;
  localparam int IdxW       = 4;

  // Accepted string lengths
  localparam logic [CountW-1:0] LenHm        = 5'd4;
  localparam logic [CountW-1:0] LenHmSec     = 5'd7;
  localparam logic [CountW-1:0] LenMdhm      = 5'd8;
  localparam logic [CountW-1:0] LenMdhmY2    = 5'd10;
  localparam logic [CountW-1:0] LenMdhmSec   = 5'd11;
  localparam logic [CountW-1:0] LenMdhmY4    = 5'd12;
  localparam logic [CountW-1:0] LenMdhmY2Sec = 5'd13;
  localparam logic [CountW-1:0] LenMdhmY4Sec = 5'd15;

  typedef logic [7:0]         char_t;
  typedef logic signed [12:0] pair_t;
  typedef logic signed [18:0] year_t;

  typedef struct packed {
    logic        parse_status;
    logic [3:0]  month_value;
    logic [4:0]  day_value;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;
    logic [10:0] year_value;
    logic        has_month_day;
    logic        has_seconds;
    logic        has_year;
  } result_t;

  // (hi - '0') * 10 + (lo - '0'), no digit check
  function automatic pair_t pair_value(input char_t hi_ch, input char_t lo_ch);
    pair_t hi_v;
    pair_t lo_v;
    hi_v = $signed({5'b0, hi_ch}) - 13'sd48;
    lo_v = $signed({5'b0, lo_ch}) - 13'sd48;
    return (hi_v * 13'sd10) + lo_v;
  endfunction

endpackage

### src/dtsp_in_if.sv
// Input channel: one character per transaction, last character marked.
interface dtsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

### src/dtsp_out_if.sv
// Result channel: decode status, date/time fields and presence flags.
interface dtsp_out_if;
  logic        valid;
  logic        ready;
  logic        parse_status;
  logic [3:0]  month_value;
  logic [4:0]  day_value;
  logic [4:0]  hour_value;
  logic [5:0]  minute_value;
  logic [5:0]  second_value;
  logic [10:0] year_value;
  logic        has_month_day;
  logic        has_seconds;
  logic        has_year;

  modport source (output valid, output parse_status, output month_value,
                  output day_value, output hour_value, output minute_value,
                  output second_value, output year_value, output has_month_day,
                  output has_seconds, output has_year, input ready);
  modport sink   (input valid, input parse_status, input month_value,
                  input day_value, input hour_value, input minute_value,
                  input second_value, input year_value, input has_month_day,
                  input has_seconds, input has_year, output ready);
endinterface

### src/date_time_string_parse_core.sv
// The end_of_text transaction writes its result to the result register, or the skid.
// One character per cycle while ready is high; decode and range checks sit between the
//   character store and the result register, so strings may follow back to back.
// A two-entry output buffer (result register plus skid) keeps input flowing
//   while a result waits; ready drops only when both entries are full.
// Synchronous reset (rst_n low) clears the character count and both valid flags.
module date_time_string_parse_core (
  input  logic        clk,
  input  logic        rst_n,
  dtsp_in_if.sink     in_ch,
  dtsp_out_if.source  out_ch
);
  import dtsp_pkg::*;

  char_t             store_r [StoreDepth];
  logic [CountW-1:0] count_r;
  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] count_nxt;

  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  logic    in_take;
  logic    produce;
  logic    out_take;
  logic    store_wr;

  char_t   eff [StoreDepth];
  pair_t   p01, p23, p45, p67, p89, p1011;
  pair_t   p56, p910, p1112, p1314;
  pair_t   month, day, hour, minute, second;
  year_t   year2, year4, year;
  logic    len_ok, md, sec, yr2, yr4, ok;
  result_t res;

  assign in_ch.ready = !skid_valid_r;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign produce     = in_take && in_ch.end_of_text;
  assign out_take    = out_valid_r && out_ch.ready;
  assign store_wr    = count_r < CountW'(StoreDepth);
  assign count_inc   = (count_r < CountW'(CountSat)) ? count_r + 1'b1 : count_r;
  assign count_nxt   = in_ch.end_of_text ? '0 : count_inc;

  // Character store and length count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_take) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && store_wr) begin
      store_r[count_r[IdxW-1:0]] <= in_ch.text_byte;
    end
  end

  // String as seen with the incoming character merged in
  always_comb begin
    for (int p = 0; p < StoreDepth; p++) begin
      eff[p] = (store_wr && count_r[IdxW-1:0] == IdxW'(p)) ? in_ch.text_byte
                                                            : store_r[p];
    end
  end

  // Pair values at every position a format can use
  always_comb begin
    p01   = pair_value(eff[0], eff[1]);
    p23   = pair_value(eff[2], eff[3]);
    p45   = pair_value(eff[4], eff[5]);
    p67   = pair_value(eff[6], eff[7]);
    p89   = pair_value(eff[8], eff[9]);
    p1011 = pair_value(eff[10], eff[11]);
    p56   = pair_value(eff[5], eff[6]);
    p910  = pair_value(eff[9], eff[10]);
    p1112 = pair_value(eff[11], eff[12]);
    p1314 = pair_value(eff[13], eff[14]);
  end

  // Format select by final length
  always_comb begin
    len_ok = 1'b1;
    md     = 1'b0;
    sec    = 1'b0;
    yr2    = 1'b0;
    yr4    = 1'b0;
    second = p56;
    case (count_inc)
      LenHm:        ;
      LenHmSec:     begin sec = 1'b1; second = p56; end
      LenMdhm:      md = 1'b1;
      LenMdhmSec:   begin md = 1'b1; sec = 1'b1; second = p910; end
      LenMdhmY2:    begin md = 1'b1; yr2 = 1'b1; end
      LenMdhmY2Sec: begin md = 1'b1; yr2 = 1'b1; sec = 1'b1; second = p1112; end
      LenMdhmY4:    begin md = 1'b1; yr4 = 1'b1; end
      LenMdhmY4Sec: begin md = 1'b1; yr4 = 1'b1; sec = 1'b1; second = p1314; end
      default:      len_ok = 1'b0;
    endcase
  end

  // Field decode and range checks
  always_comb begin
    month = p01;
    day   = p23;
    hour  = md ? p45 : p01;
    minute = md ? p67 : p23;
    year2 = (p89 > 13'sd70) ? 19'(p89) + 19'sd1900 : 19'(p89) + 19'sd2000;
    year4 = (19'(p89) * 19'sd100) + 19'(p1011);
    year  = yr4 ? year4 : year2;

    ok = len_ok
      && (!md || (month >= 13'sd1 && month <= 13'sd12 && day >= 13'sd1 && day <= 13'sd31))
      && hour >= 13'sd0 && hour <= 13'sd23
      && minute >= 13'sd0 && minute <= 13'sd59
      && (!(yr2 || yr4) || (year >= 19'sd1970 && year <= 19'sd2038))
      && (!sec || (second >= 13'sd0 && second <= 13'sd59));

    res = '0;
    if (!ok) begin
      res.parse_status = 1'b1;
    end else begin
      res.month_value   = md ? 4'(month) : '0;
      res.day_value     = md ? 5'(day) : '0;
      res.hour_value    = 5'(hour);
      res.minute_value  = 6'(minute);
      res.second_value  = sec ? 6'(second) : '0;
      res.year_value    = (yr2 || yr4) ? 11'(year) : '0;
      res.has_month_day = md;
      res.has_seconds   = sec;
      res.has_year      = yr2 || yr4;
    end
  end

  // Output register with skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (produce) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // Result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.parse_status  = out_r.parse_status;
  assign out_ch.month_value   = out_r.month_value;
  assign out_ch.day_value     = out_r.day_value;
  assign out_ch.hour_value    = out_r.hour_value;
  assign out_ch.minute_value  = out_r.minute_value;
  assign out_ch.second_value  = out_r.second_value;
  assign out_ch.year_value    = out_r.year_value;
  assign out_ch.has_month_day = out_r.has_month_day;
  assign out_ch.has_seconds   = out_r.has_seconds;
  assign out_ch.has_year      = out_r.has_year;

endmodule

### src/dtsp_checker.sv
// Port-level checker for the date/time string decoder, bound to the top level.
`include "date_time_string_parse_core_assert.svh"

module dtsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        parse_status,
  input logic [3:0]  month_value,
  input logic [4:0]  day_value,
  input logic [4:0]  hour_value,
  input logic [5:0]  minute_value,
  input logic [5:0]  second_value,
  input logic [10:0] year_value,
  input logic        has_month_day,
  input logic        has_seconds,
  input logic        has_year
);
  logic [40:0] bundle;
  logic        all_zero;
  logic        absent_zero;
  logic        good_range;

  assign bundle = {parse_status, month_value, day_value, hour_value, minute_value,
                   second_value, year_value, has_month_day, has_seconds, has_year};

  // Rejected transaction carries nothing else
  assign all_zero = bundle[39:0] == '0;

  // Absent fields read as zero
  assign absent_zero = (has_month_day || (month_value == 4'd0 && day_value == 5'd0))
                    && (has_seconds || second_value == 6'd0)
                    && (has_year || year_value == 11'd0);

  // Present fields lie in range
  assign good_range = (!has_month_day || (month_value >= 4'd1 && month_value <= 4'd12
                                          && day_value >= 5'd1))
                   && hour_value <= 5'd23 && minute_value <= 6'd59
                   && second_value <= 6'd59
                   && (!has_year || (year_value >= 11'd1970 && year_value <= 11'd2038));

  `DTSP_ASSERT(a_reject_zero, (out_valid && parse_status) |-> all_zero)
  `DTSP_ASSERT(a_absent_zero, (out_valid && !parse_status) |-> absent_zero)
  `DTSP_ASSERT(a_field_range, (out_valid && !parse_status) |-> good_range)
  `DTSP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(bundle))

endmodule

bind date_time_string_parse_core dtsp_checker u_dtsp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .parse_status  (out_ch.parse_status),
  .month_value   (out_ch.month_value),
  .day_value     (out_ch.day_value),
  .hour_value    (out_ch.hour_value),
  .minute_value  (out_ch.minute_value),
  .second_value  (out_ch.second_value),
  .year_value    (out_ch.year_value),
  .has_month_day (out_ch.has_month_day),
  .has_seconds   (out_ch.has_seconds),
  .has_year      (out_ch.has_year)
);

### sim/tb_top.sv
// Self-checking testbench for the date/time string decoder: random and directed strings.
module tb_top;
  import dtsp_pkg::*;

  localparam int          StallLimit = 2000;
  localparam int          HoldLen    = 150;
  localparam logic [7:0]  DigitZero  = 8'h30;
  localparam logic [7:0]  DotChar    = 8'h2E;

  // Expected-result ledger: mirrors the character store and decodes each string
  class date_ledger;
    logic [7:0]        chars [StoreDepth];
    logic [CountW-1:0] nchars;
    result_t           awaited [$];
    int                errors;

    function new();
      nchars = '0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Two stored characters taken as a signed decimal pair, no digit check
    function int pair_at(int pos);
      return (int'(chars[pos]) - 48) * 10 + (int'(chars[pos + 1]) - 48);
    endfunction

    function result_t decode_string();
      result_t r;
      bit      md, sec, y2, y4, ok;
      int      base, sec_at, mon, day, hr, mn, sc, yr, yy;
      r = '0;
      md = 0; sec = 0; y2 = 0; y4 = 0; ok = 1;
      base = 0; sec_at = 0; mon = 0; day = 0; sc = 0; yr = 0;
      case (nchars)
        LenHm:        ;
        LenHmSec:     begin sec = 1; sec_at = 5; end
        LenMdhm:      md = 1;
        LenMdhmSec:   begin md = 1; sec = 1; sec_at = 9; end
        LenMdhmY2:    begin md = 1; y2 = 1; end
        LenMdhmY2Sec: begin md = 1; y2 = 1; sec = 1; sec_at = 11; end
        LenMdhmY4:    begin md = 1; y4 = 1; end
        LenMdhmY4Sec: begin md = 1; y4 = 1; sec = 1; sec_at = 13; end
        default:      ok = 0;
      endcase
      if (!ok) begin
        r.parse_status = 1'b1;
        return r;
      end
      if (md) begin
        mon  = pair_at(0);
        day  = pair_at(2);
        base = 4;
        ok = ok && mon >= 1 && mon <= 12 && day >= 1 && day <= 31;
      end
      hr = pair_at(base);
      mn = pair_at(base + 2);
      ok = ok && hr >= 0 && hr <= 23 && mn >= 0 && mn <= 59;
      if (y2) begin
        yy = pair_at(8);
        yr = (yy > 70) ? yy + 1900 : yy + 2000;
      end else if (y4) begin
        yr = pair_at(8) * 100 + pair_at(10);
      end
      if (y2 || y4) ok = ok && yr >= 1970 && yr <= 2038;
      if (sec) begin
        sc = pair_at(sec_at);
        ok = ok && sc >= 0 && sc <= 59;
      end
      if (!ok) begin
        r.parse_status = 1'b1;
        return r;
      end
      r.month_value   = 4'(mon);
      r.day_value     = 5'(day);
      r.hour_value    = 5'(hr);
      r.minute_value  = 6'(mn);
      r.second_value  = 6'(sc);
      r.year_value    = 11'(yr);
      r.has_month_day = md;
      r.has_seconds   = sec;
      r.has_year      = y2 || y4;
      return r;
    endfunction

    // Accepted input transaction
    function void note_char(logic [7:0] b, logic last);
      if (nchars < StoreDepth) chars[nchars] = b;
      if (nchars < CountSat) nchars++;
      if (last) begin
        awaited.push_back(decode_string());
        nchars = '0;
      end
    endfunction

    function string show(result_t r);
      return $sformatf("st=%0d mon=%0d day=%0d hr=%0d min=%0d sec=%0d yr=%0d md=%0d s=%0d y=%0d",
                       r.parse_status, r.month_value, r.day_value, r.hour_value,
                       r.minute_value, r.second_value, r.year_value, r.has_month_day,
                       r.has_seconds, r.has_year);
    endfunction

    function void flag(string what, result_t want, result_t got);
      errors++;
      if (errors <= 10)
        $display("MISMATCH %s at %0t: expected {%s} got {%s}", what, $realtime,
                 show(want), show(got));
    endfunction

    // Accepted result transaction
    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        flag("no string pending", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.parse_status  !== want.parse_status  || got.month_value  !== want.month_value ||
          got.day_value     !== want.day_value     || got.hour_value   !== want.hour_value  ||
          got.minute_value  !== want.minute_value  || got.second_value !== want.second_value ||
          got.year_value    !== want.year_value    || got.has_month_day !== want.has_month_day ||
          got.has_seconds   !== want.has_seconds   || got.has_year     !== want.has_year)
        flag("field", want, got);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dtsp_in_if  in_ch();
  dtsp_out_if out_ch();

  date_time_string_parse_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  date_ledger ledger = new();
  logic [7:0] text_q [$];
  int         sent_chars  = 0;
  int         hold_cycles = 0;
  bit         send_idle   = 0;
  bit         sink_idle   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Channel monitor: note inputs first, then check results
  always @(posedge clk) begin : watch_channels
    result_t got;
    if (rst_n && in_ch.valid && in_ch.ready)
      ledger.note_char(in_ch.text_byte, in_ch.end_of_text);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.parse_status  = out_ch.parse_status;
      got.month_value   = out_ch.month_value;
      got.day_value     = out_ch.day_value;
      got.hour_value    = out_ch.hour_value;
      got.minute_value  = out_ch.minute_value;
      got.second_value  = out_ch.second_value;
      got.year_value    = out_ch.year_value;
      got.has_month_day = out_ch.has_month_day;
      got.has_seconds   = out_ch.has_seconds;
      got.has_year      = out_ch.has_year;
      ledger.check_result(got);
    end
  end

  // Result sink: ready bursts, random stall bursts, one long hold on request
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Offer one character and hold it until accepted; valid stays high afterwards
  task automatic send_char(input logic [7:0] b, input logic last);
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_chars++;
  endtask

  task automatic send_text_q();
    foreach (text_q[i]) begin
      if (send_idle && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      send_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    foreach (s[i]) text_q.push_back(8'(s[i]));
    send_text_q();
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  function automatic void push_pair(int v);
    text_q.push_back(DigitZero + 8'(v / 10));
    text_q.push_back(DigitZero + 8'(v % 10));
  endfunction

  // Mostly in range, with edges and some two-digit values outside it
  function automatic int pick_field(int lo, int hi);
    case ($urandom_range(0, 19))
      0:       return lo;
      1:       return hi;
      2:       return $urandom_range(0, 99);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int pick_year2();
    case ($urandom_range(0, 9))
      0:       return 70;
      1:       return 71;
      2:       return 38;
      3:       return 39;
      default: return ($urandom_range(0, 67) + 71) % 100;
    endcase
  endfunction

  function automatic int pick_year4();
    case ($urandom_range(0, 11))
      0:       return 1969;
      1:       return 1970;
      2:       return 2038;
      3:       return 2039;
      4:       return $urandom_range(0, 9999);
      default: return 1970 + $urandom_range(0, 68);
    endcase
  endfunction

  // Mostly well-formed timestamps; some with a corrupted byte, some pure noise
  task automatic build_random_string();
    int kind, layout, n, yr;
    bit with_sec;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      n = $urandom_range(1, 24);
      repeat (n)
        text_q.push_back(kind == 8 ? 8'($urandom_range(0, 255))
                                   : DigitZero + 8'($urandom_range(0, 9)));
    end else begin
      layout   = $urandom_range(0, 3);
      with_sec = $urandom_range(0, 1);
      if (layout != 0) begin
        push_pair(pick_field(1, 12));
        push_pair(pick_field(1, 31));
      end
      push_pair(pick_field(0, 23));
      push_pair(pick_field(0, 59));
      if (layout == 2) begin
        push_pair(pick_year2());
      end else if (layout == 3) begin
        yr = pick_year4();
        push_pair(yr / 100);
        push_pair(yr % 100);
      end
      if (with_sec) begin
        // separator character is not checked by the block
        text_q.push_back($urandom_range(0, 15) == 0 ? 8'($urandom_range(0, 255)) : DotChar);
        push_pair(pick_field(0, 59));
      end
      if (kind == 7) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic send_random_until(input int total);
    while (sent_chars < total) begin
      build_random_string();
      send_text_q();
    end
  endtask

  initial begin : stimulus
    int mark;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field maxima, zero time with seconds, latest year, bad length, zero byte
    send_text("2359");
    send_text("0000.59");
    send_text("1231000038");
    text_q.delete();
    text_q.push_back(8'hFF);
    send_text_q();
    text_q.delete();
    text_q.push_back(DigitZero);
    text_q.push_back(8'h00);
    text_q.push_back(DigitZero);
    text_q.push_back(DigitZero);
    send_text_q();

    // Random with idling on both sides
    send_idle = 1;
    sink_idle = 1;
    send_random_until(400);

    // Sender waits for every result before going on
    drain_results();

    // Long receiver hold while the sender keeps offering
    send_idle   = 0;
    hold_cycles = HoldLen;
    mark        = sent_chars;
    send_random_until(mark + 200);

    send_idle = 1;
    send_random_until(700);

    // Closing stretch with no idling
    send_idle = 0;
    sink_idle = 0;
    send_random_until(850);

    drain_results();
    repeat (10) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/dtsp_pkg.sv
src/dtsp_in_if.sv
src/dtsp_out_if.sv
src/date_time_string_parse_core.sv
src/dtsp_checker.sv
sim/tb_top.sv
